FILE: hdl/swt_pkg.sv
// Shared types, result codes and slot lookup tables for the sliding window tracker.
package swt_pkg;

  localparam int unsigned SEND_WINDOW_DEF = 8;
  localparam int unsigned RECV_WINDOW_DEF = 8;

  localparam int unsigned SEQ_W  = 8;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned SEQ_N  = 1 << SEQ_W;

  typedef enum logic [2:0] {
    KIND_TX      = 3'd0,
    KIND_FREED   = 3'd1,
    KIND_DELIVER = 3'd2,
    KIND_ACK     = 3'd3,
    KIND_FULL    = 3'd4
  } kind_t;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_DECODE  = 6'b000010,
    ST_SEND    = 6'b000100,
    ST_FREE    = 6'b001000,
    ST_DELIVER = 6'b010000,
    ST_ACK     = 6'b100000
  } state_t;

  typedef logic [SEQ_W-1:0] seq_t;
  typedef seq_t mod_tbl_t [0:SEQ_N-1];

  // Builds the table of n mod modulus for every sequence number by counting, so the
  // hardware only does a constant lookup.
  function automatic mod_tbl_t mod_table(input int unsigned modulus);
    mod_tbl_t    t;
    int unsigned r;
    r = 0;
    for (int unsigned i = 0; i < SEQ_N; i++) begin
      t[i] = SEQ_W'(r);
      r    = (r + 1 >= modulus) ? 0 : r + 1;
    end
    return t;
  endfunction

endpackage

FILE: hdl/sliding_window_tracker.sv
// Sliding window tracker: sequence-number engine for a selective-repeat link.
// A send request is decoded, then its single result is loaded once the output is free.
// A header is decoded, then gives one result per freed or delivered slot, a step
// to find the end of the delivery run and one result for the ack.
// Throughput: one item at a time; in_stall stays high from acceptance until the last
// result is loaded into the output register. Synchronous active-low reset clears the
// counters and all receive marks at once.
module sliding_window_tracker #(
  parameter int unsigned SEND_WINDOW = swt_pkg::SEND_WINDOW_DEF,
  parameter int unsigned RECV_WINDOW = swt_pkg::RECV_WINDOW_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_frame_seq,
  input  logic [7:0] in_frame_ack,
  input  logic       in_ack_valid,
  input  logic       in_has_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_seq_value,
  output logic [2:0] out_slot_index,
  output logic       out_last
);

  localparam int unsigned RIDX_W = (RECV_WINDOW > 1) ? $clog2(RECV_WINDOW) : 1;
  localparam swt_pkg::mod_tbl_t SEND_MOD = swt_pkg::mod_table(SEND_WINDOW);
  localparam swt_pkg::mod_tbl_t RECV_MOD = swt_pkg::mod_table(RECV_WINDOW);
  localparam swt_pkg::seq_t SEND_LIM = swt_pkg::SEQ_W'(SEND_WINDOW);
  localparam swt_pkg::seq_t RECV_LIM = swt_pkg::SEQ_W'(RECV_WINDOW);

  swt_pkg::state_t state_r, state_nxt;

  swt_pkg::seq_t last_acked_r, last_acked_nxt;
  swt_pkg::seq_t last_sent_r, last_sent_nxt;
  swt_pkg::seq_t next_exp_r, next_exp_nxt;
  logic [RECV_WINDOW-1:0] marks_r, marks_nxt;

  logic          cmd_r, ackv_r, data_r;
  swt_pkg::seq_t fseq_r, fack_r;

  logic                        out_valid_r;
  swt_pkg::kind_t              out_kind_r;
  swt_pkg::seq_t               out_seq_r;
  logic [swt_pkg::SLOT_W-1:0]  out_slot_r;
  logic                        out_last_r;

  logic                        emit, emit_last;
  swt_pkg::kind_t              emit_kind;
  swt_pkg::seq_t               emit_seq;
  logic [swt_pkg::SLOT_W-1:0]  emit_slot;

  // Shared sequence adder: increments the selected counter, or steps back one for the ack.
  swt_pkg::seq_t add_a, add_b, add_sum;

  swt_pkg::seq_t outstanding, ack_pos, rx_pos;
  logic          ack_go, mark_hit, rx_go, out_free, in_accept;
  logic [RIDX_W-1:0]          fseq_idx, ne_idx;
  logic [swt_pkg::SLOT_W-1:0] send_slot, ne_slot;

  assign in_stall  = (state_r != swt_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    unique case (state_r)
      swt_pkg::ST_FREE:    add_a = last_acked_r;
      swt_pkg::ST_DELIVER: add_a = next_exp_r;
      swt_pkg::ST_ACK:     add_a = next_exp_r;
      default:             add_a = last_sent_r;
    endcase
    add_b = (state_r == swt_pkg::ST_ACK) ? '1 : swt_pkg::SEQ_W'(1);
  end
  assign add_sum = add_a + add_b;

  assign outstanding = last_sent_r - last_acked_r;
  assign ack_pos     = fack_r - last_acked_r - swt_pkg::SEQ_W'(1);
  assign ack_go      = ackv_r && (ack_pos < outstanding);
  assign rx_pos      = fseq_r - next_exp_r;
  assign mark_hit    = data_r && (rx_pos < RECV_LIM);
  assign rx_go       = data_r && (fseq_r == next_exp_r);

  assign fseq_idx  = RECV_MOD[fseq_r][RIDX_W-1:0];
  assign ne_idx    = RECV_MOD[next_exp_r][RIDX_W-1:0];
  assign ne_slot   = RECV_MOD[next_exp_r][swt_pkg::SLOT_W-1:0];
  assign send_slot = SEND_MOD[add_sum][swt_pkg::SLOT_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    last_acked_nxt = last_acked_r;
    last_sent_nxt  = last_sent_r;
    next_exp_nxt   = next_exp_r;
    marks_nxt      = marks_r;
    emit           = 1'b0;
    emit_last      = 1'b0;
    emit_kind      = swt_pkg::KIND_TX;
    emit_seq       = add_sum;
    emit_slot      = send_slot;
    unique case (state_r)
      swt_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = swt_pkg::ST_DECODE;
        end
      end
      swt_pkg::ST_DECODE: begin
        if (cmd_r && mark_hit) begin
          marks_nxt[fseq_idx] = 1'b1;
        end
        if (!cmd_r) begin
          state_nxt = swt_pkg::ST_SEND;
        end else if (ack_go) begin
          state_nxt = swt_pkg::ST_FREE;
        end else if (rx_go) begin
          state_nxt = swt_pkg::ST_DELIVER;
        end else begin
          state_nxt = swt_pkg::ST_IDLE;
        end
      end
      swt_pkg::ST_SEND: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          if (outstanding >= SEND_LIM) begin
            emit_kind = swt_pkg::KIND_FULL;
          end else begin
            emit_kind     = swt_pkg::KIND_TX;
            last_sent_nxt = add_sum;
          end
          state_nxt = swt_pkg::ST_IDLE;
        end
      end
      swt_pkg::ST_FREE: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_kind      = swt_pkg::KIND_FREED;
          emit_last      = (add_sum == fack_r) && !rx_go;
          last_acked_nxt = add_sum;
          if (add_sum == fack_r) begin
            state_nxt = rx_go ? swt_pkg::ST_DELIVER : swt_pkg::ST_IDLE;
          end
        end
      end
      swt_pkg::ST_DELIVER: begin
        if (!marks_r[ne_idx]) begin
          state_nxt = swt_pkg::ST_ACK;
        end else if (out_free) begin
          emit              = 1'b1;
          emit_kind         = swt_pkg::KIND_DELIVER;
          emit_seq          = next_exp_r;
          emit_slot         = ne_slot;
          marks_nxt[ne_idx] = 1'b0;
          next_exp_nxt      = add_sum;
        end
      end
      swt_pkg::ST_ACK: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_kind = swt_pkg::KIND_ACK;
          emit_slot = '0;
          state_nxt = swt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = swt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= swt_pkg::ST_IDLE;
      last_acked_r <= '0;
      last_sent_r  <= '0;
      next_exp_r   <= '0;
      marks_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_acked_r <= last_acked_nxt;
      last_sent_r  <= last_sent_nxt;
      next_exp_r   <= next_exp_nxt;
      marks_r      <= marks_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r  <= in_cmd;
      fseq_r <= in_frame_seq;
      fack_r <= in_frame_ack;
      ackv_r <= in_ack_valid;
      data_r <= in_has_data;
    end
    if (emit) begin
      out_kind_r <= emit_kind;
      out_seq_r  <= emit_seq;
      out_slot_r <= emit_slot;
      out_last_r <= emit_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_seq_value  = out_seq_r;
  assign out_slot_index = out_slot_r;
  assign out_last       = out_last_r;

  // Between items the slot of the next expected frame is always unmarked.
  a_ne_slot_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swt_pkg::ST_IDLE) |-> !marks_r[ne_idx])
    else $error("receive slot of next expected frame marked while idle");

  // The send side never holds more frames than the window allows.
  a_outstanding: assert property (@(posedge clk) disable iff (!rst_n)
    outstanding <= SEND_LIM)
    else $error("outstanding frames exceed send window");

  // Every freed result advances the acknowledged number by exactly one.
  a_free_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swt_pkg::ST_FREE && emit) |=>
      (last_acked_r == $past(last_acked_r) + swt_pkg::SEQ_W'(1)))
    else $error("freed slot did not advance last acked");

  // The final result of an item hands control back to the input side.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last) |=> (state_r == swt_pkg::ST_IDLE))
    else $error("final result not followed by idle");

  // A result is only loaded when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !emit)
    else $error("output register overwritten while stalled");

endmodule

FILE: bench/sliding_window_tracker_tb.sv
// Self-checking testbench for the sliding window tracker: predicted results versus the DUT.
`timescale 1ns / 1ps

module sliding_window_tracker_tb;

  localparam int unsigned SEND_WIN = swt_pkg::SEND_WINDOW_DEF;
  localparam int unsigned RECV_WIN = swt_pkg::RECV_WINDOW_DEF;

  localparam logic CMD_SEND   = 1'b0;
  localparam logic CMD_HEADER = 1'b1;

  typedef struct {
    logic          cmd;
    swt_pkg::seq_t frame_seq;
    swt_pkg::seq_t frame_ack;
    logic          ack_valid;
    logic          has_data;
  } link_item_t;

  typedef struct {
    swt_pkg::kind_t kind;
    swt_pkg::seq_t  seq_value;
    logic [2:0]     slot_index;
    logic           last;
  } link_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_cmd = 1'b0;
  logic [7:0] in_frame_seq = 8'd0;
  logic [7:0] in_frame_ack = 8'd0;
  logic       in_ack_valid = 1'b0;
  logic       in_has_data = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_kind;
  logic [7:0] out_seq_value;
  logic [2:0] out_slot_index;
  logic       out_last;

  sliding_window_tracker dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_frame_seq  (in_frame_seq),
    .in_frame_ack  (in_frame_ack),
    .in_ack_valid  (in_ack_valid),
    .in_has_data   (in_has_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_seq_value (out_seq_value),
    .out_slot_index(out_slot_index),
    .out_last      (out_last)
  );

  always #2 clk = ~clk;

  link_item_t   pending_items[$];
  link_result_t expected_results[$];

  // Predicted link state.
  swt_pkg::seq_t acked_upto = 8'd0;
  swt_pkg::seq_t sent_upto = 8'd0;
  swt_pkg::seq_t rx_next = 8'd0;
  bit            rx_marked [RECV_WIN];

  link_result_t held_result;
  bit           have_held = 1'b0;
  int unsigned  burst_len;

  // Stimulus planning state, kept apart from the prediction.
  swt_pkg::seq_t plan_sent = 8'd0;
  swt_pkg::seq_t plan_acked = 8'd0;
  swt_pkg::seq_t plan_rx = 8'd0;

  int unsigned n_items_total = 0;
  int unsigned n_items_taken = 0;
  int unsigned n_results = 0;
  int unsigned n_refused = 0;
  int unsigned max_burst = 0;
  int unsigned n_errors = 0;

  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  logic        hold_off = 1'b0;
  int unsigned send_wait = 0;
  int unsigned stall_left = 0;

  function automatic link_item_t make_item(logic cmd, swt_pkg::seq_t fseq,
                                           swt_pkg::seq_t fack, logic ackv, logic data);
    link_item_t it;
    it.cmd       = cmd;
    it.frame_seq = fseq;
    it.frame_ack = fack;
    it.ack_valid = ackv;
    it.has_data  = data;
    return it;
  endfunction

  function automatic bit in_window(swt_pkg::seq_t s, swt_pkg::seq_t lo, swt_pkg::seq_t hi);
    swt_pkg::seq_t pos;
    swt_pkg::seq_t span;
    pos  = s - lo;
    span = hi - lo + 8'd1;
    return pos < span;
  endfunction

  // Results are held back by one so that the final one of an item can be marked.
  task automatic queue_result(swt_pkg::kind_t kind, swt_pkg::seq_t seq, logic [2:0] slot);
    if (have_held) expected_results.push_back(held_result);
    held_result.kind       = kind;
    held_result.seq_value  = seq;
    held_result.slot_index = slot;
    held_result.last       = 1'b0;
    have_held              = 1'b1;
    burst_len++;
  endtask

  task automatic predict_item(link_item_t it);
    swt_pkg::seq_t nxt;
    swt_pkg::seq_t in_flight;
    burst_len = 0;
    if (it.cmd == CMD_SEND) begin
      nxt       = sent_upto + 8'd1;
      in_flight = sent_upto - acked_upto;
      if (in_flight >= SEND_WIN) begin
        queue_result(swt_pkg::KIND_FULL, nxt, 3'(nxt % SEND_WIN));
        n_refused++;
      end else begin
        sent_upto = nxt;
        queue_result(swt_pkg::KIND_TX, nxt, 3'(nxt % SEND_WIN));
      end
    end else begin
      if (it.ack_valid && in_window(it.frame_ack, acked_upto + 8'd1, sent_upto)) begin
        do begin
          acked_upto++;
          queue_result(swt_pkg::KIND_FREED, acked_upto, 3'(acked_upto % SEND_WIN));
        end while (acked_upto != it.frame_ack);
      end
      if (it.has_data && in_window(it.frame_seq, rx_next, rx_next + 8'(RECV_WIN - 1))) begin
        rx_marked[it.frame_seq % RECV_WIN] = 1'b1;
        if (it.frame_seq == rx_next) begin
          while (rx_marked[rx_next % RECV_WIN]) begin
            queue_result(swt_pkg::KIND_DELIVER, rx_next, 3'(rx_next % RECV_WIN));
            rx_marked[rx_next % RECV_WIN] = 1'b0;
            rx_next++;
          end
          queue_result(swt_pkg::KIND_ACK, rx_next - 8'd1, 3'd0);
        end
      end
    end
    if (have_held) begin
      held_result.last = 1'b1;
      expected_results.push_back(held_result);
      have_held = 1'b0;
    end
    if (burst_len > max_burst) max_burst = burst_len;
  endtask

  function automatic void compare_field(string name, int unsigned want, logic [7:0] got);
    if (got !== 8'(want)) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  task automatic check_result();
    link_result_t want;
    n_results++;
    if (expected_results.size() == 0) begin
      $error("unexpected result: kind %0d seq_value %0d slot_index %0d last %0d",
             out_kind, out_seq_value, out_slot_index, out_last);
      n_errors++;
      return;
    end
    want = expected_results.pop_front();
    compare_field("kind", want.kind, {5'd0, out_kind});
    compare_field("seq_value", want.seq_value, out_seq_value);
    compare_field("slot_index", want.slot_index, {5'd0, out_slot_index});
    compare_field("last", want.last, {7'd0, out_last});
  endtask

  // Picks the acknowledgement field of a header. Most valid acks move the plan
  // forward; the others are stale or beyond the outstanding window.
  task automatic pick_ack(output logic valid, output swt_pkg::seq_t ack);
    swt_pkg::seq_t span;
    span  = plan_sent - plan_acked;
    valid = 1'($urandom_range(0, 1));
    ack   = 8'($urandom);
    if (valid) begin
      if (span != 0 && $urandom_range(0, 4) != 0) begin
        ack        = plan_acked + 8'($urandom_range(1, span));
        plan_acked = ack;
      end else if ($urandom_range(0, 1) == 0) begin
        ack = plan_acked;
      end else begin
        ack = plan_sent + 8'($urandom_range(1, 248));
      end
    end
  endtask

  // Handshake tracking, prediction and checking, all on the rising edge.
  always @(posedge clk) begin
    in_fire  <= rst_n && in_valid && !in_stall;
    out_fire <= rst_n && out_valid && !out_stall;
    if (rst_n && in_valid && !in_stall) begin
      predict_item(make_item(in_cmd, in_frame_seq, in_frame_ack, in_ack_valid, in_has_data));
      n_items_taken++;
    end
    if (rst_n && out_valid && !out_stall) check_result();
  end

  // Sender.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // The item stays on the bus until it is taken.
    end else if (send_wait > 0) begin
      in_valid <= 1'b0;
      send_wait--;
    end else if (pending_items.size() > 0) begin
      in_cmd       <= pending_items[0].cmd;
      in_frame_seq <= pending_items[0].frame_seq;
      in_frame_ack <= pending_items[0].frame_ack;
      in_ack_valid <= pending_items[0].ack_valid;
      in_has_data  <= pending_items[0].has_data;
      in_valid     <= 1'b1;
      void'(pending_items.pop_front());
      send_wait = ((n_items_taken / 40) % 4 == 3) ? 0 : $urandom_range(0, 5);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver. The stall for each result counts down only while a result waits.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_fire) stall_left = ((n_results / 60) % 4 == 1) ? 0 : $urandom_range(0, 5);
      out_stall <= hold_off || stall_left > 0;
      if (out_valid && stall_left > 0) stall_left--;
    end
  end

  // One long hold-off on the result side, so that the block backs up into its input.
  initial begin
    wait (n_results >= 90);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (250) @(negedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #1_000_000;
    $display("Timeout with %0d of %0d items taken and %0d results outstanding.",
             n_items_taken, n_items_total, expected_results.size());
    $display("** sliding_window_tracker: FAILED **");
    $finish;
  end

  initial begin
    int unsigned   n_rand;
    int unsigned   k;
    int unsigned   j;
    int unsigned   action;
    swt_pkg::seq_t order [8];
    swt_pkg::seq_t tmp;
    swt_pkg::seq_t ack;
    logic          ackv;

    // Directed part. Nothing is outstanding yet, and the data lies far outside.
    pending_items.push_back(make_item(CMD_HEADER, 8'd200, 8'd0, 1'b1, 1'b1));
    for (int i = 0; i < 8; i++) pending_items.push_back(make_item(CMD_SEND, 0, 0, 0, 0));
    pending_items.push_back(make_item(CMD_SEND, 0, 0, 0, 0));  // window full
    // Ack beyond the window; data at the top edge of the receive window.
    pending_items.push_back(make_item(CMD_HEADER, 8'd7, 8'd20, 1'b1, 1'b1));
    pending_items.push_back(make_item(CMD_HEADER, 8'd8, 8'd255, 1'b0, 1'b1));
    for (int i = 1; i <= 6; i++)
      pending_items.push_back(make_item(CMD_HEADER, 8'(i), 8'd0, 1'b0, 1'b1));
    // Frees the whole send window and delivers the whole receive window.
    pending_items.push_back(make_item(CMD_HEADER, 8'd0, 8'd8, 1'b1, 1'b1));
    pending_items.push_back(make_item(CMD_SEND, 8'd255, 8'd255, 1'b1, 1'b1));
    pending_items.push_back(make_item(CMD_HEADER, 8'd255, 8'd255, 1'b0, 1'b0));
    pending_items.push_back(make_item(CMD_HEADER, 8'd9, 8'd9, 1'b1, 1'b1));
    pending_items.push_back(make_item(CMD_HEADER, 8'd8, 8'd0, 1'b0, 1'b1));
    // Stale ack and data just behind the receive window.
    pending_items.push_back(make_item(CMD_HEADER, 8'd7, 8'd9, 1'b1, 1'b1));
    plan_sent  = 8'd9;
    plan_acked = 8'd9;
    plan_rx    = 8'd10;

    n_rand = 0;
    while (n_rand < 196) begin
      action = $urandom_range(0, 9);
      if (action <= 3) begin
        if (8'(plan_sent - plan_acked) < SEND_WIN) plan_sent++;
        pending_items.push_back(make_item(CMD_SEND, 8'($urandom), 8'($urandom),
                                          1'($urandom), 1'($urandom)));
        n_rand++;
      end else if (action <= 6) begin
        // A run of data frames that arrives in shuffled order.
        k = $urandom_range(1, 8);
        for (int i = 0; i < k; i++) order[i] = plan_rx + 8'(i);
        for (int i = k - 1; i > 0; i--) begin
          j        = $urandom_range(0, i);
          tmp      = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < k; i++) begin
          pick_ack(ackv, ack);
          pending_items.push_back(make_item(CMD_HEADER, order[i], ack, ackv, 1'b1));
        end
        plan_rx += 8'(k);
        n_rand  += k;
      end else if (action == 7) begin
        pick_ack(ackv, ack);
        pending_items.push_back(make_item(CMD_HEADER, 8'($urandom), ack, ackv, 1'b0));
        n_rand++;
      end else if (action == 8) begin
        // Data and ack both outside their windows.
        pending_items.push_back(make_item(CMD_HEADER, plan_rx + 8'($urandom_range(8, 255)),
                                          plan_sent + 8'($urandom_range(1, 248)),
                                          1'b1, 1'b1));
        n_rand++;
      end else begin
        pending_items.push_back(make_item(CMD_HEADER, 8'($urandom), 8'($urandom),
                                          1'b0, 1'b0));
        n_rand++;
      end
    end
    n_items_total = pending_items.size();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    wait (n_items_taken == n_items_total);
    while (expected_results.size() > 0) @(posedge clk);
    // A last header may cause nothing; give any stray result time to show.
    repeat (40) @(posedge clk);

    $display("Ran %0d link items (%0d send requests refused on a full window).",
             n_items_total, n_refused);
    $display("Checked %0d results; the longest run from one item was %0d.",
             n_results, max_burst);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("** sliding_window_tracker: PASSED **");
    end else begin
      $display("** sliding_window_tracker: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sliding_window_tracker.f
hdl/swt_pkg.sv
hdl/sliding_window_tracker.sv
bench/sliding_window_tracker_tb.sv
